@@ rtl/mslw_pkg.sv @@
// ----------------------------------------------------------------------------
// mslw_pkg: shared types for the link watchdog
// Link state and item mode codes, the item and result words.
// ----------------------------------------------------------------------------
package mslw_pkg;

  localparam logic [31:0] AGE_MAX = 32'hFFFF_FFFF;

  localparam logic CFG_STALE_LIMIT   = 1'b0;
  localparam logic CFG_EVAL_INTERVAL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE         = 2'd0,
    ST_HEALTHY      = 2'd1,
    ST_RECONNECTING = 2'd2,
    ST_DISCONNECTED = 2'd3
  } link_state_t;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_STAMP  = 3'd1,
    MODE_REACH  = 3'd2,
    MODE_ARM    = 3'd3,
    MODE_DISARM = 3'd4,
    MODE_EVAL   = 3'd5
  } mode_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] source;
    logic       reachable;
    logic       reach_known;
  } item_t;

  typedef struct packed {
    link_state_t old_state;
    link_state_t new_state;
    logic [31:0] since_ms;
  } result_t;

endpackage

@@ rtl/mslw_min.sv @@
// ----------------------------------------------------------------------------
// mslw_min: newest age search
// Smallest age among the seen sources, with a flag for any source seen.
// ----------------------------------------------------------------------------
module mslw_min #(
  parameter int SOURCES = 6
) (
  input  logic [31:0]        ages [SOURCES],
  input  logic [SOURCES-1:0] seen,
  output logic [31:0]        min_age,
  output logic               any_seen
);
  import mslw_pkg::*;

  logic [31:0] best;

  always_comb begin
    best = AGE_MAX;
    for (int i = 0; i < SOURCES; i++) begin
      if (seen[i] && ages[i] < best) begin
        best = ages[i];
      end
    end
  end

  assign any_seen = |seen;
  assign min_age  = any_seen ? best : 32'd0;

endmodule

@@ rtl/mslw_core.sv @@
// ----------------------------------------------------------------------------
// mslw_core: watchdog state and item decode
// Holds ages, flags and link state; decides one item and its result.
// ----------------------------------------------------------------------------
module mslw_core #(
  parameter int SOURCES = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  mslw_pkg::item_t   item,
  input  logic [15:0]       stale_limit,
  input  logic [15:0]       eval_interval,
  output logic              emit,
  output mslw_pkg::result_t result
);
  import mslw_pkg::*;

  logic               armed, armed_next;
  link_state_t        link_state, link_state_next;
  logic               reach_flag, reach_flag_next;
  logic               reach_known_flag, reach_known_flag_next;
  logic [31:0]        source_age [SOURCES];
  logic [31:0]        source_age_next [SOURCES];
  logic [SOURCES-1:0] source_seen, source_seen_next;
  logic [15:0]        interval_count, interval_count_next;

  logic [31:0] min_age;
  logic        any_seen;
  logic [15:0] count_inc;
  logic        do_eval;
  logic [31:0] eval_age;
  logic        eval_any;
  link_state_t eval_state;

  mslw_min #(.SOURCES(SOURCES)) u_min (
    .ages     (source_age),
    .seen     (source_seen),
    .min_age  (min_age),
    .any_seen (any_seen)
  );

  assign count_inc = interval_count + 16'd1;

  always_comb begin
    armed_next            = armed;
    link_state_next       = link_state;
    reach_flag_next       = reach_flag;
    reach_known_flag_next = reach_known_flag;
    source_age_next       = source_age;
    source_seen_next      = source_seen;
    interval_count_next   = interval_count;
    do_eval               = 1'b0;
    eval_age              = min_age;
    eval_any              = any_seen;
    emit                  = 1'b0;
    result                = '{old_state: link_state, new_state: link_state, since_ms: 32'd0};
    eval_state            = ST_DISCONNECTED;

    case (mode_t'(item.mode))
      MODE_TICK: begin
        if (armed) begin
          for (int i = 0; i < SOURCES; i++) begin
            if (source_seen[i] && source_age[i] != AGE_MAX) begin
              source_age_next[i] = source_age[i] + 32'd1;
            end
          end
          // every seen age moved up by one, so does their minimum
          if (any_seen && min_age != AGE_MAX) begin
            eval_age = min_age + 32'd1;
          end
          if (count_inc >= eval_interval) begin
            interval_count_next = 16'd0;
            do_eval             = 1'b1;
          end else begin
            interval_count_next = count_inc;
          end
        end
      end
      MODE_STAMP: begin
        if (armed && int'(item.source) < SOURCES) begin
          for (int i = 0; i < SOURCES; i++) begin
            if (int'(item.source) == i) begin
              source_age_next[i]  = 32'd0;
              source_seen_next[i] = 1'b1;
            end
          end
          eval_age = 32'd0;
          eval_any = 1'b1;
          do_eval  = (link_state != ST_HEALTHY);
        end
      end
      MODE_REACH: begin
        if (item.reachable != reach_flag || item.reach_known != reach_known_flag) begin
          reach_flag_next       = item.reachable;
          reach_known_flag_next = item.reach_known;
          do_eval               = 1'b1;
        end
      end
      MODE_ARM: begin
        if (!armed) begin
          armed_next            = 1'b1;
          link_state_next       = ST_DISCONNECTED;
          reach_flag_next       = 1'b0;
          reach_known_flag_next = 1'b0;
          source_seen_next      = '0;
          interval_count_next   = 16'd0;
          for (int i = 0; i < SOURCES; i++) source_age_next[i] = 32'd0;
          emit   = 1'b1;
          result = '{old_state: ST_IDLE, new_state: ST_DISCONNECTED, since_ms: 32'd0};
        end
      end
      MODE_DISARM: begin
        if (armed) begin
          armed_next            = 1'b0;
          link_state_next       = ST_IDLE;
          reach_flag_next       = 1'b0;
          reach_known_flag_next = 1'b0;
          source_seen_next      = '0;
          interval_count_next   = 16'd0;
          for (int i = 0; i < SOURCES; i++) source_age_next[i] = 32'd0;
          emit   = (link_state != ST_IDLE);
          result = '{old_state: link_state, new_state: ST_IDLE, since_ms: 32'd0};
        end
      end
      MODE_EVAL: begin
        do_eval = 1'b1;
      end
      default: begin
      end
    endcase

    // evaluation sees the flags and ages as this item leaves them
    if (eval_any && eval_age < {16'd0, stale_limit}) begin
      eval_state = ST_HEALTHY;
    end else if (reach_known_flag_next && reach_flag_next) begin
      eval_state = ST_RECONNECTING;
    end else begin
      eval_state = ST_DISCONNECTED;
    end

    if (do_eval && armed && eval_state != link_state) begin
      link_state_next = eval_state;
      emit            = 1'b1;
      result          = '{old_state: link_state, new_state: eval_state, since_ms: eval_age};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed            <= 1'b0;
      link_state       <= ST_IDLE;
      reach_flag       <= 1'b0;
      reach_known_flag <= 1'b0;
      source_seen      <= '0;
      interval_count   <= 16'd0;
      for (int i = 0; i < SOURCES; i++) source_age[i] <= 32'd0;
    end else if (fire) begin
      armed            <= armed_next;
      link_state       <= link_state_next;
      reach_flag       <= reach_flag_next;
      reach_known_flag <= reach_known_flag_next;
      source_seen      <= source_seen_next;
      interval_count   <= interval_count_next;
      source_age       <= source_age_next;
    end
  end

endmodule

@@ rtl/multi_source_link_watchdog_unit.sv @@
// ----------------------------------------------------------------------------
// multi_source_link_watchdog_unit: heartbeat link watchdog
// Input register, watchdog core and result register with configuration.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one word per event: tick,
//   stamp, reachability update, arm, disarm or evaluate now
//   output channel (out_valid / out_stall) carries one word per change of
//   link state: old state, new state and the newest seen age
//   config channel (cfg_valid / cfg_ready) writes stale limit (index 0)
//   or evaluation interval (index 1); cfg_ready is always high, writes
//   belong to idle periods
// timing
//   a word taken into the input register is decided by the core when it
//   moves on, and its result is then held in the result register
//   one word per cycle unless the output stalls; the state update plus the
//   min search over the source ages is the combinational path that sets this
// reset
//   rst is synchronous: disarmed, idle link, ages and flags cleared,
//   registers back to stale limit 1000 and interval 250, both channels empty
// stalls
//   a stalled result holds; the held input word waits in the input register
//   and in_stall rises until the result register frees up
module multi_source_link_watchdog_unit #(
  parameter int SOURCES = 6
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [2:0]  source,
  input  logic        reachable,
  input  logic        reach_known,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  old_state,
  output logic [1:0]  new_state,
  output logic [31:0] since_ms,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import mslw_pkg::*;

  // configuration registers
  logic [15:0] stale_limit;
  logic [15:0] eval_interval;

  // input register
  item_t in_q;
  logic  in_q_valid;

  // result register
  result_t out_q;

  logic    advance;
  logic    emit;
  result_t core_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit   <= 16'd1000;
      eval_interval <= 16'd250;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_STALE_LIMIT) stale_limit <= cfg_data;
      if (cfg_index == CFG_EVAL_INTERVAL) eval_interval <= cfg_data;
    end
  end

  // the held word moves on when the result slot is empty or being taken
  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= '{mode: mode, source: source, reachable: reachable,
                reach_known: reach_known};
    end
  end

  mslw_core #(.SOURCES(SOURCES)) u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (advance),
    .item          (in_q),
    .stale_limit   (stale_limit),
    .eval_interval (eval_interval),
    .emit          (emit),
    .result        (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_q <= core_result;
    end
  end

  assign old_state = out_q.old_state;
  assign new_state = out_q.new_state;
  assign since_ms  = out_q.since_ms;

endmodule
